/* src/swfad_pkg.sv */
package swfad_pkg;

	// Default table sizes
	localparam int WINDOW_DEPTH_DEF     = 256;
	localparam int PAIR_ENTRIES_DEF     = 64;
	localparam int PORT_SET_ENTRIES_DEF = 1024;
	localparam int FLOW_ENTRIES_DEF     = 128;
	localparam int DEST_ENTRIES_DEF     = 64;

	// Field widths
	localparam int TS_W       = 17;
	localparam int ADDR_W     = 32;
	localparam int PORT_W     = 16;
	localparam int KEY_W      = 2 * ADDR_W;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 8;
	localparam int SCAN_THR_W = 11;
	localparam int FAIL_LIM_W = 9;
	localparam int SPIKE_W    = 9;
	localparam int DIST_OUT_W = 11;
	localparam int CNT_OUT_W  = 9;

	// Register reset values
	localparam logic [TS_W-1:0]       WINDOW_RST = 17'd60;
	localparam logic [SCAN_THR_W-1:0] SCAN_RST   = 11'd10;
	localparam logic [FAIL_LIM_W-1:0] FAIL_RST   = 9'd5;
	localparam logic [SPIKE_W-1:0]    SPIKE_RST  = 9'd30;

	// Growth over the last alert level that raises a new spike alert
	localparam int SPIKE_STEP = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SECONDS = 8'd0,
		CFG_SCAN_THRESHOLD = 8'd1,
		CFG_FAIL_LIMIT     = 8'd2,
		CFG_SPIKE_LEVEL    = 8'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_PUSH,
		ST_RET_RD,
		ST_RET_CHK,
		ST_SCAN,
		ST_APPLY,
		ST_FINAL
	} state_t;

	typedef enum logic [2:0] {
		MODE_RFLOW,
		MODE_RDEST,
		MODE_PAIR,
		MODE_PORT,
		MODE_FLOW,
		MODE_DEST
	} mode_t;

endpackage

/* src/sliding_window_flow_anomaly_detector_unit.sv */
// Each request stores its event in the window, retires expired or overflowing window events,
// then scans the pair, port-set, flow and destination tables and writes back its entries;
// an early key match shortens each table scan. Throughput: one request at a time, set
// by the linear scan of each table memory through one shared compare unit, one entry a cycle.
// Reset: asynchronous, clears the control state, counters and valid bits at once;
// table memories need no clearing pass and the block is ready as soon as reset is released.
module sliding_window_flow_anomaly_detector_unit
	import swfad_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int PAIR_ENTRIES = PAIR_ENTRIES_DEF,
	parameter int PORT_SET_ENTRIES = PORT_SET_ENTRIES_DEF,
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
	parameter int DEST_ENTRIES = DEST_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TS_W-1:0]       timestamp,
	input  logic [ADDR_W-1:0]     src_addr,
	input  logic [ADDR_W-1:0]     dst_addr,
	input  logic [PORT_W-1:0]     dst_port,
	input  logic                  failed,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  scan_alert,
	output logic                  brute_alert,
	output logic                  spike_alert,
	output logic [DIST_OUT_W-1:0] port_spread,
	output logic [CNT_OUT_W-1:0]  fail_count,
	output logic [CNT_OUT_W-1:0]  dst_connections,
	output logic                  table_full,
	output logic                  window_overflow,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int WAW  = $clog2(WINDOW_DEPTH);
	localparam int WFW  = $clog2(WINDOW_DEPTH + 1);
	localparam int PAW  = $clog2(PAIR_ENTRIES);
	localparam int PCW  = $clog2(PAIR_ENTRIES + 1);
	localparam int SAW  = $clog2(PORT_SET_ENTRIES);
	localparam int SCNW = $clog2(PORT_SET_ENTRIES + 1);
	localparam int FAW  = $clog2(FLOW_ENTRIES);
	localparam int DAW  = $clog2(DEST_ENTRIES);
	localparam int DW   = SCNW;
	localparam int CW   = WFW;
	localparam int MAX_PF = (PAIR_ENTRIES > PORT_SET_ENTRIES) ? PAIR_ENTRIES : PORT_SET_ENTRIES;
	localparam int MAX_FD = (FLOW_ENTRIES > DEST_ENTRIES) ? FLOW_ENTRIES : DEST_ENTRIES;
	localparam int MAXE = (MAX_PF > MAX_FD) ? MAX_PF : MAX_FD;
	localparam int SCW  = $clog2(MAXE + 1);
	localparam int WIN_W  = KEY_W + TS_W + PORT_W + 1;
	localparam int PAIR_W = KEY_W + DW + 1;
	localparam int PREC_W = PAW + PORT_W;
	localparam int FLOW_W = KEY_W + PORT_W + CW + 1;
	localparam int DEST_W = ADDR_W + 2 * CW;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   scan_go;

	// Configuration registers
	logic [TS_W-1:0]       win_sec_q;
	logic [SCAN_THR_W-1:0] scan_thr_q;
	logic [FAIL_LIM_W-1:0] fail_lim_q;
	logic [SPIKE_W-1:0]    spike_lvl_q;

	// Request being worked on
	logic [TS_W-1:0]   ts_q;
	logic [KEY_W-1:0]  key_q;
	logic [PORT_W-1:0] port_q;
	logic              failed_q;

	logic [WAW-1:0] head_q;
	logic [WFW-1:0] fill_q;
	logic           evict_q;
	logic           ovf_q;
	logic           full_q;
	logic [PCW-1:0] pair_cnt_q;
	logic [SCNW-1:0] port_cnt_q;
	logic [FLOW_ENTRIES-1:0] flow_vld_q;
	logic [DEST_ENTRIES-1:0] dest_vld_q;

	// Scan unit
	logic [SCW-1:0] cnt_q;
	logic [SCW-1:0] idx_s1;
	logic           pend_s1;
	logic           found_q;
	logic [SCW-1:0] hit_idx_q;
	logic           free_ok_q;
	logic [SCW-1:0] free_idx_q;
	logic [SCW-1:0] lim;
	logic           slot_vld;
	logic           key_match;
	logic           hit;
	logic           issue;
	logic           scan_end;
	logic [KEY_W-1:0]  tgt_key;
	logic [PORT_W-1:0] tgt_port;

	// Per-request working records
	logic           p_ok_q;
	logic [PAW-1:0] p_idx_q;
	logic [DW-1:0]  p_dist_q;
	logic           p_alert_q;
	logic           f_ok_q;
	logic [FAW-1:0] f_idx_q;
	logic [CW-1:0]  f_fails_q;
	logic           f_alert_q;
	logic           d_ok_q;
	logic [DAW-1:0] d_idx_q;
	logic [CW-1:0]  d_conns_q;
	logic [CW-1:0]  d_last_q;

	// Memory ports
	logic              win_we, win_re;
	logic [WAW-1:0]    oldest;
	logic [WIN_W-1:0]  win_rd;
	logic              pair_we, pair_re;
	logic [PAIR_W-1:0] pair_rd;
	logic              port_we, port_re;
	logic [PREC_W-1:0] port_rd;
	logic              flow_we, flow_re, flow_set, flow_clr;
	logic [FAW-1:0]    flow_wa;
	logic [FLOW_W-1:0] flow_wd, flow_rd;
	logic              dest_we, dest_re, dest_set, dest_clr;
	logic [DAW-1:0]    dest_wa;
	logic [DEST_W-1:0] dest_wd, dest_rd;

	logic [WFW:0] oldest_wide;
	logic         win_full;
	logic         expired;
	logic         pair_ok;
	logic         out_free;
	logic         scan_fire, brute_fire, spike_fire;

	// Fields of the read records
	logic [KEY_W-1:0]  w_key;
	logic [TS_W-1:0]   w_ts;
	logic [PORT_W-1:0] w_port;
	logic              w_failed;
	logic [KEY_W-1:0]  pr_key;
	logic [DW-1:0]     pr_dist;
	logic              pr_alert;
	logic [PAW-1:0]    pt_pair;
	logic [PORT_W-1:0] pt_port;
	logic [KEY_W-1:0]  fl_key;
	logic [PORT_W-1:0] fl_port;
	logic [CW-1:0]     fl_fails;
	logic              fl_alert;
	logic [ADDR_W-1:0] ds_addr;
	logic [CW-1:0]     ds_conns;
	logic [CW-1:0]     ds_last;

	assign w_key    = win_rd[WIN_W-1 -: KEY_W];
	assign w_ts     = win_rd[PORT_W+1 +: TS_W];
	assign w_port   = win_rd[1 +: PORT_W];
	assign w_failed = win_rd[0];
	assign pr_key   = pair_rd[PAIR_W-1 -: KEY_W];
	assign pr_dist  = pair_rd[1 +: DW];
	assign pr_alert = pair_rd[0];
	assign pt_pair  = port_rd[PORT_W +: PAW];
	assign pt_port  = port_rd[0 +: PORT_W];
	assign fl_key   = flow_rd[FLOW_W-1 -: KEY_W];
	assign fl_port  = flow_rd[CW+1 +: PORT_W];
	assign fl_fails = flow_rd[1 +: CW];
	assign fl_alert = flow_rd[0];
	assign ds_addr  = dest_rd[DEST_W-1 -: ADDR_W];
	assign ds_conns = dest_rd[CW +: CW];
	assign ds_last  = dest_rd[0 +: CW];

	// Oldest window slot: head minus fill, modulo the depth
	assign oldest_wide = (WFW+1)'(head_q) + (WFW+1)'(WINDOW_DEPTH) - (WFW+1)'(fill_q);
	assign oldest = (oldest_wide >= (WFW+1)'(WINDOW_DEPTH))
		? WAW'(oldest_wide - (WFW+1)'(WINDOW_DEPTH)) : WAW'(oldest_wide);
	assign win_full = (fill_q == WFW'(WINDOW_DEPTH));
	assign expired  = ((18'(w_ts) + 18'(win_sec_q)) < 18'(ts_q));
	assign out_free = !out_valid || out_ready;

	// Select the key the scan looks for
	always_comb begin
		if (mode_q == MODE_RFLOW || mode_q == MODE_RDEST) begin
			tgt_key  = w_key;
			tgt_port = w_port;
		end else begin
			tgt_key  = key_q;
			tgt_port = port_q;
		end
	end

	// Shared compare unit of the table scan
	always_comb begin
		lim       = '0;
		slot_vld  = 1'b1;
		key_match = 1'b0;
		case (mode_q) inside
			MODE_PAIR: begin
				lim       = SCW'(pair_cnt_q);
				key_match = (pr_key == key_q);
			end
			MODE_PORT: begin
				lim       = SCW'(port_cnt_q);
				key_match = (pt_pair == p_idx_q) && (pt_port == port_q);
			end
			MODE_RFLOW, MODE_FLOW: begin
				lim       = SCW'(FLOW_ENTRIES);
				slot_vld  = flow_vld_q[idx_s1[FAW-1:0]];
				key_match = (fl_key == tgt_key) && (fl_port == tgt_port);
			end
			MODE_RDEST, MODE_DEST: begin
				lim       = SCW'(DEST_ENTRIES);
				slot_vld  = dest_vld_q[idx_s1[DAW-1:0]];
				key_match = (ds_addr == tgt_key[ADDR_W-1:0]);
			end
			default: begin
				lim = '0;
			end
		endcase
	end

	assign hit      = pend_s1 && slot_vld && key_match;
	assign issue    = (state_q == ST_SCAN) && (cnt_q < lim) && !hit;
	assign scan_end = (state_q == ST_SCAN) && (hit || (!pend_s1 && (cnt_q >= lim)));
	assign pair_ok  = found_q || (pair_cnt_q < PCW'(PAIR_ENTRIES));

	// Alert decisions on the final counts
	assign scan_fire = (scan_thr_q != '0) && p_ok_q && !p_alert_q
		&& (32'(p_dist_q) >= 32'(scan_thr_q));
	assign brute_fire = (fail_lim_q != '0) && f_ok_q && (f_fails_q != '0) && !f_alert_q
		&& (32'(f_fails_q) >= 32'(fail_lim_q));
	assign spike_fire = (spike_lvl_q != '0) && d_ok_q && (d_conns_q != '0)
		&& (32'(d_conns_q) >= 32'(spike_lvl_q))
		&& ((32'(d_last_q) < 32'(spike_lvl_q))
			|| (32'(d_conns_q) >= 32'(d_last_q) + 32'(SPIKE_STEP)));

	// Next state
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		scan_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = win_full ? ST_RET_RD : ST_PUSH;
			end
			ST_PUSH: begin
				state_d = ST_RET_RD;
			end
			ST_RET_RD: begin
				if (evict_q && (fill_q == '0)) begin
					scan_go = 1'b1;
					mode_d  = MODE_PAIR;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RET_CHK;
				end
			end
			ST_RET_CHK: begin
				scan_go = 1'b1;
				state_d = ST_SCAN;
				if (!evict_q || expired) begin
					mode_d = w_failed ? MODE_RFLOW : MODE_RDEST;
				end else begin
					mode_d = MODE_PAIR;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				unique case (mode_q)
					MODE_RFLOW: begin
						scan_go = 1'b1;
						mode_d  = MODE_RDEST;
						state_d = ST_SCAN;
					end
					MODE_RDEST: begin
						state_d = evict_q ? ST_RET_RD : ST_PUSH;
					end
					MODE_PAIR: begin
						scan_go = 1'b1;
						mode_d  = pair_ok ? MODE_PORT : MODE_FLOW;
						state_d = ST_SCAN;
					end
					MODE_PORT: begin
						scan_go = 1'b1;
						mode_d  = MODE_FLOW;
						state_d = ST_SCAN;
					end
					MODE_FLOW: begin
						scan_go = 1'b1;
						mode_d  = MODE_DEST;
						state_d = ST_SCAN;
					end
					MODE_DEST: begin
						state_d = ST_FINAL;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FINAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory strobes and write data
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		win_we   = (state_q == ST_PUSH);
		win_re   = (state_q == ST_RET_RD) && !(evict_q && (fill_q == '0));
		pair_re  = issue && (mode_q == MODE_PAIR);
		port_re  = issue && (mode_q == MODE_PORT);
		flow_re  = issue && ((mode_q == MODE_FLOW) || (mode_q == MODE_RFLOW));
		dest_re  = issue && ((mode_q == MODE_DEST) || (mode_q == MODE_RDEST));
		pair_we  = (state_q == ST_FINAL) && out_free && p_ok_q;
		port_we  = (state_q == ST_APPLY) && (mode_q == MODE_PORT) && !found_q
			&& (port_cnt_q < SCNW'(PORT_SET_ENTRIES));
		flow_we  = 1'b0;
		flow_set = 1'b0;
		flow_clr = 1'b0;
		flow_wa  = f_idx_q;
		flow_wd  = {key_q, port_q, f_fails_q, f_alert_q | brute_fire};
		dest_we  = 1'b0;
		dest_set = 1'b0;
		dest_clr = 1'b0;
		dest_wa  = d_idx_q;
		dest_wd  = {key_q[ADDR_W-1:0], d_conns_q, spike_fire ? d_conns_q : d_last_q};
		if ((state_q == ST_APPLY) && (mode_q == MODE_RFLOW) && found_q && (fl_fails != '0)) begin
			flow_we  = 1'b1;
			flow_wa  = hit_idx_q[FAW-1:0];
			flow_wd  = {fl_key, fl_port, fl_fails - CW'(1), fl_alert};
			flow_clr = (fl_fails == CW'(1)) && !fl_alert;
		end else if ((state_q == ST_FINAL) && out_free && f_ok_q) begin
			flow_we  = 1'b1;
			flow_set = 1'b1;
		end
		if ((state_q == ST_APPLY) && (mode_q == MODE_RDEST) && found_q && (ds_conns != '0)) begin
			dest_we  = 1'b1;
			dest_wa  = hit_idx_q[DAW-1:0];
			dest_wd  = {ds_addr, ds_conns - CW'(1), ds_last};
			dest_clr = (ds_conns == CW'(1)) && (ds_last == '0);
		end else if ((state_q == ST_FINAL) && out_free && d_ok_q) begin
			dest_we  = 1'b1;
			dest_set = 1'b1;
		end
	end

	// Sequencer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_PAIR;
			win_sec_q   <= WINDOW_RST;
			scan_thr_q  <= SCAN_RST;
			fail_lim_q  <= FAIL_RST;
			spike_lvl_q <= SPIKE_RST;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_SECONDS: win_sec_q   <= cfg_data[TS_W-1:0];
					CFG_SCAN_THRESHOLD: scan_thr_q  <= cfg_data[SCAN_THR_W-1:0];
					CFG_FAIL_LIMIT:     fail_lim_q  <= cfg_data[FAIL_LIM_W-1:0];
					CFG_SPIKE_LEVEL:    spike_lvl_q <= cfg_data[SPIKE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ts_q     <= timestamp;
			key_q    <= {src_addr, dst_addr};
			port_q   <= dst_port;
			failed_q <= failed;
		end
	end

	// Window pointers, table counters and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fill_q     <= '0;
			evict_q    <= 1'b0;
			ovf_q      <= 1'b0;
			full_q     <= 1'b0;
			pair_cnt_q <= '0;
			port_cnt_q <= '0;
			flow_vld_q <= '0;
			dest_vld_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				ovf_q   <= 1'b0;
				full_q  <= 1'b0;
				evict_q <= 1'b0;
			end
			if (state_q == ST_START) begin
				ovf_q <= win_full;
			end
			if (state_q == ST_PUSH) begin
				head_q  <= (head_q == WAW'(WINDOW_DEPTH - 1)) ? '0 : head_q + WAW'(1);
				fill_q  <= fill_q + WFW'(1);
				evict_q <= 1'b1;
			end
			if (state_q == ST_APPLY) begin
				case (mode_q)
					MODE_RDEST: begin
						fill_q <= fill_q - WFW'(1);
					end
					MODE_PAIR: begin
						if (!found_q) begin
							if (pair_ok) begin
								pair_cnt_q <= pair_cnt_q + PCW'(1);
							end else begin
								full_q <= 1'b1;
							end
						end
					end
					MODE_PORT: begin
						if (port_we) begin
							port_cnt_q <= port_cnt_q + SCNW'(1);
						end else if (!found_q) begin
							full_q <= 1'b1;
						end
					end
					MODE_FLOW: begin
						if (failed_q && !found_q && !free_ok_q) begin
							full_q <= 1'b1;
						end
					end
					MODE_DEST: begin
						if (!found_q && !free_ok_q) begin
							full_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (flow_clr) begin
				flow_vld_q[flow_wa] <= 1'b0;
			end
			if (flow_set) begin
				flow_vld_q[flow_wa] <= 1'b1;
			end
			if (dest_clr) begin
				dest_vld_q[dest_wa] <= 1'b0;
			end
			if (dest_set) begin
				dest_vld_q[dest_wa] <= 1'b1;
			end
		end
	end

	// Advance the scan: issue one read a cycle, compare the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			free_ok_q <= 1'b0;
			found_q   <= 1'b0;
		end else if (scan_go) begin
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			pend_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + SCW'(1);
			end
			if (pend_s1 && !slot_vld && !free_ok_q) begin
				free_ok_q <= 1'b1;
			end
			if (scan_end) begin
				found_q <= hit;
			end
		end
	end

	// Scan indexes
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			idx_s1 <= cnt_q;
			if (pend_s1 && !slot_vld && !free_ok_q) begin
				free_idx_q <= idx_s1;
			end
			if (scan_end) begin
				hit_idx_q <= idx_s1;
			end
		end
	end

	// Build the working records from the scan results
	always_ff @(posedge clk) begin
		if ((state_q == ST_RET_CHK) || (state_q == ST_RET_RD && evict_q && fill_q == '0)) begin
			p_ok_q <= 1'b0;
			f_ok_q <= 1'b0;
			d_ok_q <= 1'b0;
		end
		if (state_q == ST_APPLY) begin
			case (mode_q)
				MODE_PAIR: begin
					p_ok_q    <= pair_ok;
					p_idx_q   <= found_q ? hit_idx_q[PAW-1:0] : pair_cnt_q[PAW-1:0];
					p_dist_q  <= found_q ? pr_dist : '0;
					p_alert_q <= found_q ? pr_alert : 1'b0;
				end
				MODE_PORT: begin
					if (port_we) begin
						p_dist_q <= p_dist_q + DW'(1);
					end
				end
				MODE_FLOW: begin
					f_ok_q    <= found_q || (failed_q && free_ok_q);
					f_idx_q   <= found_q ? hit_idx_q[FAW-1:0] : free_idx_q[FAW-1:0];
					f_fails_q <= (found_q ? fl_fails : '0) + CW'(failed_q);
					f_alert_q <= found_q ? fl_alert : 1'b0;
				end
				MODE_DEST: begin
					d_ok_q    <= found_q || free_ok_q;
					d_idx_q   <= found_q ? hit_idx_q[DAW-1:0] : free_idx_q[DAW-1:0];
					d_conns_q <= (found_q ? ds_conns : '0) + CW'(1);
					d_last_q  <= found_q ? ds_last : '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_FINAL) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINAL) && out_free) begin
			scan_alert      <= scan_fire;
			brute_alert     <= brute_fire;
			spike_alert     <= spike_fire;
			table_full      <= full_q;
			window_overflow <= ovf_q;
			port_spread     <= !p_ok_q ? '0
				: (32'(p_dist_q) > 32'({DIST_OUT_W{1'b1}})) ? {DIST_OUT_W{1'b1}}
				: DIST_OUT_W'(p_dist_q);
			fail_count      <= !f_ok_q ? '0
				: (32'(f_fails_q) > 32'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
				: CNT_OUT_W'(f_fails_q);
			dst_connections <= !d_ok_q ? '0
				: (32'(d_conns_q) > 32'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
				: CNT_OUT_W'(d_conns_q);
		end
	end

	// Table memories
	swfad_ram #(.DATA_W(WIN_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
		.clk (clk),
		.we  (win_we),
		.wa  (head_q),
		.wd  ({key_q, ts_q, port_q, failed_q}),
		.re  (win_re),
		.ra  (oldest),
		.rd  (win_rd)
	);

	swfad_ram #(.DATA_W(PAIR_W), .DEPTH(PAIR_ENTRIES)) u_pair_ram (
		.clk (clk),
		.we  (pair_we),
		.wa  (p_idx_q),
		.wd  ({key_q, p_dist_q, p_alert_q | scan_fire}),
		.re  (pair_re),
		.ra  (cnt_q[PAW-1:0]),
		.rd  (pair_rd)
	);

	swfad_ram #(.DATA_W(PREC_W), .DEPTH(PORT_SET_ENTRIES)) u_port_ram (
		.clk (clk),
		.we  (port_we),
		.wa  (port_cnt_q[SAW-1:0]),
		.wd  ({p_idx_q, port_q}),
		.re  (port_re),
		.ra  (cnt_q[SAW-1:0]),
		.rd  (port_rd)
	);

	swfad_ram #(.DATA_W(FLOW_W), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
		.clk (clk),
		.we  (flow_we),
		.wa  (flow_wa),
		.wd  (flow_wd),
		.re  (flow_re),
		.ra  (cnt_q[FAW-1:0]),
		.rd  (flow_rd)
	);

	swfad_ram #(.DATA_W(DEST_W), .DEPTH(DEST_ENTRIES)) u_dest_ram (
		.clk (clk),
		.we  (dest_we),
		.wa  (dest_wa),
		.wd  (dest_wd),
		.re  (dest_re),
		.ra  (cnt_q[DAW-1:0]),
		.rd  (dest_rd)
	);

endmodule

/* src/swfad_ram.sv */
module swfad_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [DATA_W-1:0] wd,
	input  logic              re,
	input  logic [ADDR_W-1:0] ra,
	output logic [DATA_W-1:0] rd
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Register the read data, hold it while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

/* dv/sliding_window_flow_anomaly_detector_unit_tb.sv */
module sliding_window_flow_anomaly_detector_unit_tb;
	import swfad_pkg::*;

	localparam int WIN_N  = WINDOW_DEPTH_DEF;
	localparam int PAIR_N = PAIR_ENTRIES_DEF;
	localparam int PORT_N = PORT_SET_ENTRIES_DEF;
	localparam int FLOW_N = FLOW_ENTRIES_DEF;
	localparam int DEST_N = DEST_ENTRIES_DEF;
	localparam int STALL_LIMIT = 400000;
	localparam int MAX_TS = 86399;

	typedef struct {
		logic [TS_W-1:0]   ts;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [PORT_W-1:0] port;
		logic              fail;
	} conn_event_t;

	typedef struct {
		logic                  scan;
		logic                  brute;
		logic                  spike;
		logic [DIST_OUT_W-1:0] distinct;
		logic [CNT_OUT_W-1:0]  fails;
		logic [CNT_OUT_W-1:0]  conns;
		logic                  full;
		logic                  overflow;
	} verdict_t;

	typedef struct {
		conn_event_t ev;
		bit          typed;
		verdict_t    want;
	} stim_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid;
	logic out_ready = 1'b0;
	logic [TS_W-1:0] timestamp;
	logic [ADDR_W-1:0] src_addr, dst_addr;
	logic [PORT_W-1:0] dst_port;
	logic failed;
	logic scan_alert, brute_alert, spike_alert, table_full, window_overflow;
	logic [DIST_OUT_W-1:0] port_spread;
	logic [CNT_OUT_W-1:0] fail_count, dst_connections;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sliding_window_flow_anomaly_detector_unit dut (.*);

	// Shadow of the detector state
	int unsigned win_len, scan_thr, fail_lim, spike_lvl;
	logic [KEY_W-1:0] win_key[WIN_N];
	int unsigned win_ts[WIN_N];
	logic [PORT_W-1:0] win_port[WIN_N];
	bit win_fail[WIN_N];
	int unsigned win_head, win_fill;
	bit pair_ok[PAIR_N];
	logic [KEY_W-1:0] pair_key[PAIR_N];
	int unsigned pair_dist[PAIR_N];
	bit pair_hit[PAIR_N];
	bit pset_ok[PORT_N];
	int pset_pair[PORT_N];
	logic [PORT_W-1:0] pset_port[PORT_N];
	bit flow_ok[FLOW_N];
	logic [KEY_W-1:0] flow_key[FLOW_N];
	logic [PORT_W-1:0] flow_port[FLOW_N];
	int unsigned flow_fails[FLOW_N];
	bit flow_hit[FLOW_N];
	bit dest_ok[DEST_N];
	logic [ADDR_W-1:0] dest_addr[DEST_N];
	int unsigned dest_conns[DEST_N], dest_last[DEST_N];

	verdict_t pending_verdicts[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet;
	int stall_left = 0;
	int unsigned cur_ts;
	logic [ADDR_W-1:0] src_pool[8], dst_pool[8];
	logic [PORT_W-1:0] port_pool[24];

	function automatic int find_flow(logic [KEY_W-1:0] k, logic [PORT_W-1:0] p);
		for (int i = 0; i < FLOW_N; i++)
			if (flow_ok[i] && flow_key[i] == k && flow_port[i] == p) return i;
		return -1;
	endfunction

	function automatic int find_dest(logic [ADDR_W-1:0] a);
		for (int i = 0; i < DEST_N; i++)
			if (dest_ok[i] && dest_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic int unsigned oldest();
		return (win_head + WIN_N - win_fill) % WIN_N;
	endfunction

	// Retire the oldest stored event and drop its windowed counts
	function automatic void retire_oldest();
		int unsigned s;
		int f, d;
		s = oldest();
		if (win_fail[s]) begin
			f = find_flow(win_key[s], win_port[s]);
			if (f >= 0 && flow_fails[f] > 0) begin
				flow_fails[f]--;
				if (flow_fails[f] == 0 && !flow_hit[f]) flow_ok[f] = 0;
			end
		end
		d = find_dest(win_key[s][ADDR_W-1:0]);
		if (d >= 0 && dest_conns[d] > 0) begin
			dest_conns[d]--;
			if (dest_conns[d] == 0 && dest_last[d] == 0) dest_ok[d] = 0;
		end
		win_fill--;
	endfunction

	function automatic void clear_state();
		win_len = 32'(WINDOW_RST); scan_thr = 32'(SCAN_RST);
		fail_lim = 32'(FAIL_RST); spike_lvl = 32'(SPIKE_RST);
		win_head = 0; win_fill = 0;
		foreach (pair_ok[i]) pair_ok[i] = 0;
		foreach (pset_ok[i]) pset_ok[i] = 0;
		foreach (flow_ok[i]) flow_ok[i] = 0;
		foreach (dest_ok[i]) dest_ok[i] = 0;
	endfunction

	// Work out the verdict of one connection event and advance the shadow state
	function automatic verdict_t score_event(conn_event_t e);
		verdict_t v;
		logic [KEY_W-1:0] k;
		int p, f, d, s;
		bit seen;
		int unsigned cur;
		k = {e.src, e.dst};
		v = '{default: 0};
		if (win_fill >= WIN_N) begin
			retire_oldest();
			v.overflow = 1;
		end
		win_key[win_head] = k; win_ts[win_head] = 32'(e.ts);
		win_port[win_head] = e.port; win_fail[win_head] = e.fail;
		win_head = (win_head + 1) % WIN_N;
		win_fill++;
		while (win_fill > 0 && win_ts[oldest()] + win_len < e.ts) retire_oldest();

		p = -1;
		for (int i = 0; i < PAIR_N && p < 0; i++)
			if (pair_ok[i] && pair_key[i] == k) p = i;
		if (p < 0) begin
			for (int i = 0; i < PAIR_N && p < 0; i++)
				if (!pair_ok[i]) p = i;
			if (p < 0) v.full = 1;
			else begin
				pair_ok[p] = 1; pair_key[p] = k; pair_dist[p] = 0; pair_hit[p] = 0;
			end
		end
		if (p >= 0) begin
			seen = 0;
			for (int i = 0; i < PORT_N && !seen; i++)
				if (pset_ok[i] && pset_pair[i] == p && pset_port[i] == e.port) seen = 1;
			if (!seen) begin
				s = -1;
				for (int i = 0; i < PORT_N && s < 0; i++)
					if (!pset_ok[i]) s = i;
				if (s < 0) v.full = 1;
				else begin
					pset_ok[s] = 1; pset_pair[s] = p; pset_port[s] = e.port;
					pair_dist[p]++;
				end
			end
		end

		f = find_flow(k, e.port);
		if (e.fail) begin
			if (f < 0) begin
				for (int i = 0; i < FLOW_N && f < 0; i++)
					if (!flow_ok[i]) f = i;
				if (f < 0) v.full = 1;
				else begin
					flow_ok[f] = 1; flow_key[f] = k; flow_port[f] = e.port;
					flow_fails[f] = 0; flow_hit[f] = 0;
				end
			end
			if (f >= 0) flow_fails[f]++;
		end

		d = find_dest(e.dst);
		if (d < 0) begin
			for (int i = 0; i < DEST_N && d < 0; i++)
				if (!dest_ok[i]) d = i;
			if (d < 0) v.full = 1;
			else begin
				dest_ok[d] = 1; dest_addr[d] = e.dst; dest_conns[d] = 0; dest_last[d] = 0;
			end
		end
		if (d >= 0) dest_conns[d]++;

		// Alerts
		if (scan_thr > 0 && p >= 0 && pair_dist[p] >= scan_thr && !pair_hit[p]) begin
			v.scan = 1; pair_hit[p] = 1;
		end
		if (fail_lim > 0 && f >= 0 && flow_fails[f] > 0 && flow_fails[f] >= fail_lim
				&& !flow_hit[f]) begin
			v.brute = 1; flow_hit[f] = 1;
		end
		if (spike_lvl > 0 && d >= 0 && dest_conns[d] > 0) begin
			cur = dest_conns[d];
			if (cur >= spike_lvl && (dest_last[d] < spike_lvl || cur >= dest_last[d] + SPIKE_STEP))
					begin
				v.spike = 1; dest_last[d] = cur;
			end
		end

		if (p >= 0) v.distinct = DIST_OUT_W'(pair_dist[p] > 2047 ? 2047 : pair_dist[p]);
		if (f >= 0) v.fails = CNT_OUT_W'(flow_fails[f] > 511 ? 511 : flow_fails[f]);
		if (d >= 0) v.conns = CNT_OUT_W'(dest_conns[d] > 511 ? 511 : dest_conns[d]);
		return v;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Check each accepted result against the oldest expected verdict, and pace out_ready
	always @(posedge clk) begin
		verdict_t w;
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				w = pending_verdicts[0];
				pending_verdicts.delete(0);
				if (scan_alert !== w.scan) report("scan_alert", scan_alert, w.scan);
				if (brute_alert !== w.brute) report("brute_alert", brute_alert, w.brute);
				if (spike_alert !== w.spike) report("spike_alert", spike_alert, w.spike);
				if (port_spread !== w.distinct)
					report("port_spread", port_spread, w.distinct);
				if (fail_count !== w.fails) report("fail_count", fail_count, w.fails);
				if (dst_connections !== w.conns)
					report("dst_connections", dst_connections, w.conns);
				if (table_full !== w.full) report("table_full", table_full, w.full);
				if (window_overflow !== w.overflow)
					report("window_overflow", window_overflow, w.overflow);
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (!quiet && $urandom_range(0, 99) < 30)
				stall_left <= $urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
					: $urandom_range(10, 60);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_event(conn_event_t e, bit typed, verdict_t want);
		int gap;
		verdict_t got;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		timestamp <= e.ts; src_addr <= e.src; dst_addr <= e.dst;
		dst_port <= e.port; failed <= e.fail;
		do @(posedge clk); while (!in_ready);
		got = score_event(e);
		pending_verdicts.insert(pending_verdicts.size(), typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_WINDOW_SECONDS: win_len = val;
			CFG_SCAN_THRESHOLD: scan_thr = val;
			CFG_FAIL_LIMIT:     fail_lim = val;
			CFG_SPIKE_LEVEL:    spike_lvl = val;
			default: ;
		endcase
	endtask

	task automatic set_phase(int unsigned w, int unsigned s, int unsigned f, int unsigned k);
		drain();
		write_reg(CFG_WINDOW_SECONDS, w);
		write_reg(CFG_SCAN_THRESHOLD, s);
		write_reg(CFG_FAIL_LIMIT, f);
		write_reg(CFG_SPIKE_LEVEL, k);
	endtask

	function automatic conn_event_t random_event(int rand_port_pct);
		conn_event_t e;
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) cur_ts = $urandom_range(0, MAX_TS);
		else if (r < 8) cur_ts = cur_ts + $urandom_range(100, 20000);
		else cur_ts = cur_ts + ($urandom_range(0, 99) < 60 ? 0 : $urandom_range(1, 3));
		if (cur_ts > MAX_TS) cur_ts = MAX_TS;
		e.ts = TS_W'(cur_ts);
		e.src = $urandom_range(0, 99) < 85 ? src_pool[$urandom_range(0, 3)] : $urandom;
		e.dst = $urandom_range(0, 99) < 80 ? dst_pool[$urandom_range(0, 7)] : $urandom;
		e.port = $urandom_range(0, 99) < rand_port_pct ? 16'($urandom)
			: port_pool[$urandom_range(0, 23)];
		e.fail = $urandom_range(0, 99) < 55;
		return e;
	endfunction

	task automatic random_phase(int n, int rand_port_pct);
		verdict_t none;
		none = '{default: 0};
		cur_ts = $urandom_range(0, 1000);
		for (int i = 0; i < n; i++) begin
			if (i % 120 == 60) quiet = ~quiet;
			// Hold off until every outstanding result has come back
			if (i == n / 2) drain();
			send_event(random_event(rand_port_pct), 0, none);
		end
		quiet = 0;
	endtask

	initial begin
		stim_row_t rows[$];
		verdict_t none;
		none = '{default: 0};
		arst_n = 0; in_valid = 0; cfg_we = 0;
		cfg_index = CFG_WINDOW_SECONDS; cfg_data = 0;
		timestamp = 0; src_addr = 0; dst_addr = 0; dst_port = 0; failed = 0;
		quiet = 0;
		clear_state();
		foreach (src_pool[i]) src_pool[i] = $urandom;
		foreach (dst_pool[i]) dst_pool[i] = $urandom;
		foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part under reset settings
		rows.insert(rows.size(), '{'{0, 0, 0, 0, 1}, 1, '{0, 0, 0, 1, 1, 1, 0, 0}});
		// Old event falls out of the window, its flow and destination entries go
		rows.insert(rows.size(), '{'{MAX_TS, '1, '1, '1, 0}, 1, '{0, 0, 0, 1, 0, 1, 0, 0}});
		rows.insert(rows.size(), '{'{MAX_TS, '1, '1, '1, 1}, 1, '{0, 0, 0, 1, 1, 2, 0, 0}});
		// Timestamp running backwards
		rows.insert(rows.size(), '{'{3, 0, '1, 1, 1}, 0, none});
		rows.insert(rows.size(),
			'{'{17'h15555, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 1}, 0, none});
		rows.insert(rows.size(),
			'{'{17'h0AAAA, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 0}, 0, none});
		for (int i = 0; i < 12; i++)
			rows.insert(rows.size(), '{'{MAX_TS, 32'h1, 32'h2, 16'(i), 1}, 0, none});
		foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].want);

		set_phase(0, 1, 1, 1);
		random_phase(250, 30);
		set_phase(MAX_TS, 1024, 256, 256);
		random_phase(600, 90);
		set_phase(20, 3, 2, 4);
		random_phase(400, 30);
		set_phase(5, 0, 0, 0);
		random_phase(350, 30);

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
src/swfad_pkg.sv
src/swfad_ram.sv
src/sliding_window_flow_anomaly_detector_unit.sv
dv/sliding_window_flow_anomaly_detector_unit_tb.sv
